// File: rtl/core/ccrf_pkg.sv
// Shared types and constants for the console command receive framer.
package ccrf_pkg;

  // Console control codes, taken as their ASCII values.
  localparam logic [7:0] CTRL_R  = 8'h12;
  localparam logic [7:0] CTRL_X  = 8'h18;
  localparam logic [7:0] CTRL_Z  = 8'h1A;
  localparam logic [7:0] NEWLINE = 8'h0A;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MANUFACTURING_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_BYTE      = 1'd1;
  localparam int unsigned CFG_DATA_W = 8;

  // Receive mode, one-hot.
  typedef enum logic [2:0] {
    ST_READY = 3'b001,
    ST_BUSY  = 3'b010,
    ST_BOOT  = 3'b100
  } rx_state_t;

  // One result beat.
  typedef struct packed {
    logic       flush_queues;
    logic       push_valid;
    logic       forward_valid;
    logic [7:0] out_byte;
    logic       command_complete;
    logic       rearbitrate;
    logic       cpu_response;
  } result_t;

endpackage

// File: rtl/core/ccrf_rx_if.sv
// Received-byte channel: valid/ready handshake with one byte of payload.
interface ccrf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/core/ccrf_res_if.sv
// Result channel: valid/ready handshake with the framer's result fields.
interface ccrf_res_if;
  logic       valid;
  logic       ready;
  logic       flush_queues;
  logic       push_valid;
  logic       forward_valid;
  logic [7:0] out_byte;
  logic       command_complete;
  logic       rearbitrate;
  logic       cpu_response;

  modport source (output valid, output flush_queues, output push_valid,
                  output forward_valid, output out_byte, output command_complete,
                  output rearbitrate, output cpu_response, input ready);
  modport sink   (input valid, input flush_queues, input push_valid,
                  input forward_valid, input out_byte, input command_complete,
                  input rearbitrate, input cpu_response, output ready);
endinterface

// File: rtl/core/ccrf_decode.sv
// Priority decode of one received byte against the current receive mode.
module ccrf_decode (
  input  logic [7:0]         rx_byte,
  input  ccrf_pkg::rx_state_t state,
  input  logic               manufacturing_mode,
  input  logic [7:0]         response_byte,
  output ccrf_pkg::rx_state_t state_next,
  output ccrf_pkg::result_t  result
);

  logic is_z;
  logic is_x;
  logic is_r;
  logic is_nl;

  assign is_z  = (rx_byte == ccrf_pkg::CTRL_Z);
  assign is_x  = (rx_byte == ccrf_pkg::CTRL_X);
  assign is_r  = (rx_byte == ccrf_pkg::CTRL_R);
  assign is_nl = (rx_byte == ccrf_pkg::NEWLINE);

  // First match wins.
  always_comb begin
    state_next              = state;
    result                  = '0;
    result.out_byte         = rx_byte;
    if (is_z) begin
      result.flush_queues   = 1'b1;
      state_next            = ccrf_pkg::ST_READY;
    end else if (state == ccrf_pkg::ST_BOOT && rx_byte == response_byte) begin
      result.cpu_response   = 1'b1;
    end else if (!manufacturing_mode && is_x) begin
      // dropped
    end else if (manufacturing_mode && state == ccrf_pkg::ST_READY && !is_x) begin
      result.forward_valid  = 1'b1;
    end else if (is_r && state != ccrf_pkg::ST_BOOT) begin
      result.flush_queues   = 1'b1;
      result.rearbitrate    = 1'b1;
      state_next            = ccrf_pkg::ST_BOOT;
    end else if (state == ccrf_pkg::ST_READY && !is_nl) begin
      // only Ctrl-X in manufacturing mode reaches here unqueued
      result.push_valid     = !(manufacturing_mode && is_x);
      state_next            = ccrf_pkg::ST_BUSY;
    end else if (state == ccrf_pkg::ST_BUSY && is_nl) begin
      result.push_valid       = 1'b1;
      result.command_complete = 1'b1;
      state_next              = ccrf_pkg::ST_READY;
    end else begin
      result.push_valid     = 1'b1;
    end
  end

endmodule

// File: rtl/core/ccrf_out_buf.sv
// Output register with a skid entry so input keeps flowing while a result waits.
module ccrf_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  ccrf_pkg::result_t in_result,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ccrf_pkg::result_t out_result
);

  logic              skid_valid;
  ccrf_pkg::result_t skid_result;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_result <= skid_result;
      end else begin
        out_result <= in_result;
      end
    end else if (in_fire) begin
      skid_result <= in_result;
    end
  end

endmodule

// File: rtl/core/console_command_rx_framer_unit.sv
// Console command receive framer: top level with mode register, config and output buffer.
//
//  channel  | dir | payload                                   | handshake
//  ---------+-----+-------------------------------------------+-------------
//  rx       | in  | rx_byte[7:0]                              | valid/ready
//  res      | out | flush_queues push_valid forward_valid     | valid/ready
//           |     | out_byte[7:0] command_complete            |
//           |     | rearbitrate cpu_response                  |
//  cfg      | in  | cfg_we, cfg_index[0], cfg_wdata[7:0]      | write strobe
//
// One beat in per clock while rx.ready is high. The byte is decoded against the
// mode register in the cycle it is accepted; the mode updates on that edge and the
// result is captured on the same edge, in the output register if that is free or
// being taken, else in the skid entry; res is offered from the output register.
// A two-entry output buffer (output register plus skid entry) keeps rx.ready
// high while a single result waits; rx stalls only once both entries are full.
// Synchronous active-high reset: mode to ready, config registers to zero,
// output buffer empty.
module console_command_rx_framer_unit (
  input  logic                              clk,
  input  logic                              rst,
  ccrf_rx_if.sink                           rx,
  ccrf_res_if.source                        res,
  input  logic                              cfg_we,
  input  logic [ccrf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ccrf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  ccrf_pkg::rx_state_t state;
  ccrf_pkg::rx_state_t state_next;
  ccrf_pkg::result_t   dec_result;
  ccrf_pkg::result_t   out_result;
  logic                manufacturing_mode;
  logic [7:0]          response_byte;
  logic                in_ready;
  logic                in_fire;

  assign rx.ready = in_ready;
  assign in_fire  = rx.valid && in_ready;

  // Config writes: user must write only while idle; not enforced, no datapath interlock.
  always_ff @(posedge clk) begin
    if (rst) begin
      manufacturing_mode <= 1'b0;
      response_byte      <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        ccrf_pkg::CFG_MANUFACTURING_MODE: manufacturing_mode <= cfg_wdata[0];
        ccrf_pkg::CFG_RESPONSE_BYTE:      response_byte      <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Mode register advances on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccrf_pkg::ST_READY;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  ccrf_decode u_decode (
    .rx_byte            (rx.rx_byte),
    .state              (state),
    .manufacturing_mode (manufacturing_mode),
    .response_byte      (response_byte),
    .state_next         (state_next),
    .result             (dec_result)
  );

  ccrf_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .in_result  (dec_result),
    .in_ready   (in_ready),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .out_result (out_result)
  );

  assign res.flush_queues     = out_result.flush_queues;
  assign res.push_valid       = out_result.push_valid;
  assign res.forward_valid    = out_result.forward_valid;
  assign res.out_byte         = out_result.out_byte;
  assign res.command_complete = out_result.command_complete;
  assign res.rearbitrate      = out_result.rearbitrate;
  assign res.cpu_response     = out_result.cpu_response;

  // Ctrl-Z always lands in ready.
  a_ctrl_z_ready: assert property (@(posedge clk) disable iff (rst)
    in_fire && rx.rx_byte == ccrf_pkg::CTRL_Z |=> state == ccrf_pkg::ST_READY)
    else $error("Ctrl-Z did not return mode to ready");

  // A byte is never both queued and forwarded.
  a_push_fwd_excl: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.push_valid && res.forward_valid))
    else $error("push and forward both set");

  // Command completion only with a queued newline.
  a_complete_nl: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.command_complete |->
      res.push_valid && res.out_byte == ccrf_pkg::NEWLINE)
    else $error("command_complete without queued newline");

  // Rearbitration always flushes and enters boot.
  a_rearb_boot: assert property (@(posedge clk) disable iff (rst)
    in_fire && dec_result.rearbitrate |=> state == ccrf_pkg::ST_BOOT)
    else $error("rearbitrate without entering boot");

  // Ready drops only while a result is held in the output register.
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> res.valid)
    else $error("input stalled with empty output");

endmodule

// File: tb/sv/tb_console_command_rx_framer_unit.sv
// Self-checking testbench for the console command receive framer.
module tb_console_command_rx_framer_unit;

  // Watchdog: cycles in a row with no beat on either channel before giving up.
  localparam int unsigned STALL_LIMIT = 3000;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [ccrf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ccrf_pkg::CFG_DATA_W-1:0] cfg_wdata;

  ccrf_rx_if  rx_ch ();
  ccrf_res_if res_ch ();

  console_command_rx_framer_unit uut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the framer: mode plus the two config registers.
  ccrf_pkg::rx_state_t rx_mode   = ccrf_pkg::ST_READY;
  logic                mfg_mode  = 1'b0;
  logic [7:0]          resp_byte = 8'h00;

  // Results predicted at rx acceptance, oldest first.
  ccrf_pkg::result_t   pending_results[$];
  ccrf_pkg::result_t   want_res;
  ccrf_pkg::result_t   got_res;

  int unsigned errors        = 0;
  int unsigned bytes_sent    = 0;
  int unsigned quiet_cycles  = 0;

  // Idle knobs, in percent of cycles. recv_hold forces a long ready-low run.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned recv_hold     = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: one received byte -> one result beat, priority order of checks.
  // Updates the shadow mode in place.
  // ---------------------------------------------------------------------------
  function automatic ccrf_pkg::result_t frame_byte(input logic [7:0] b);
    ccrf_pkg::result_t r;
    r          = '0;
    r.out_byte = b;
    if (b == ccrf_pkg::CTRL_Z) begin
      // Ctrl-Z always wins: flush and back to ready.
      r.flush_queues = 1'b1;
      rx_mode        = ccrf_pkg::ST_READY;
    end else if (rx_mode == ccrf_pkg::ST_BOOT && b == resp_byte) begin
      // CPU answered arbitration; mode holds.
      r.cpu_response = 1'b1;
    end else if (!mfg_mode && b == ccrf_pkg::CTRL_X) begin
      // Ctrl-X swallowed outside manufacturing mode.
    end else if (mfg_mode && rx_mode == ccrf_pkg::ST_READY && b != ccrf_pkg::CTRL_X) begin
      // Passthrough to the second port.
      r.forward_valid = 1'b1;
    end else if (b == ccrf_pkg::CTRL_R && rx_mode != ccrf_pkg::ST_BOOT) begin
      r.flush_queues = 1'b1;
      r.rearbitrate  = 1'b1;
      rx_mode        = ccrf_pkg::ST_BOOT;
    end else if (rx_mode == ccrf_pkg::ST_READY && b != ccrf_pkg::NEWLINE) begin
      // First byte of a command. Ctrl-X here (manufacturing) opens it unqueued.
      r.push_valid = !(mfg_mode && b == ccrf_pkg::CTRL_X);
      rx_mode      = ccrf_pkg::ST_BUSY;
    end else if (rx_mode == ccrf_pkg::ST_BUSY && b == ccrf_pkg::NEWLINE) begin
      r.push_valid       = 1'b1;
      r.command_complete = 1'b1;
      rx_mode            = ccrf_pkg::ST_READY;
    end else begin
      // Newline while ready, non-newline bytes while busy, anything in boot, Ctrl-R in boot.
      r.push_valid = 1'b1;
    end
    return r;
  endfunction

  // Byte picker weighted toward the codes that steer the mode.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return ccrf_pkg::CTRL_R;
      1:       return ccrf_pkg::CTRL_X;
      2:       return ccrf_pkg::CTRL_Z;
      3:       return ccrf_pkg::NEWLINE;
      4:       return resp_byte;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver side. All inputs move on the falling edge; handshakes are sampled
  // on the rising edge. valid stays high from one beat to the next unless a
  // gap is rolled, so it is never lowered and raised in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    pending_results.push_back(frame_byte(b));
    bytes_sent++;
  endtask

  // Drop valid and wait until every predicted beat has come back.
  task automatic wait_drained();
    @(negedge clk);
    rx_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Register write; only called with the framer drained.
  task automatic write_reg(input logic [ccrf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == ccrf_pkg::CFG_MANUFACTURING_MODE) mfg_mode = data[0];
    else resp_byte = data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Both registers; junk in the unused upper bits of the mode write.
  task automatic set_config(input logic mfg, input logic [7:0] rsp);
    write_reg(ccrf_pkg::CFG_MANUFACTURING_MODE, {7'($urandom_range(127)), mfg});
    write_reg(ccrf_pkg::CFG_RESPONSE_BYTE, rsp);
  endtask

  // Mostly well-formed traffic: commands ending in newline, boot
  // arbitration runs, and some loose noise in between.
  task automatic send_traffic(input int unsigned n_bytes);
    int unsigned target;
    int unsigned kind;
    int unsigned len;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      kind = $urandom_range(9);
      if (kind < 5) begin
        len = $urandom_range(12, 1);
        if ($urandom_range(7) == 0) send_byte(ccrf_pkg::CTRL_X);
        repeat (len) begin
          if ($urandom_range(3) == 0) send_byte(pick_byte());
          else send_byte(8'($urandom_range(8'h7e, 8'h20)));
        end
        if ($urandom_range(5) != 0) send_byte(ccrf_pkg::NEWLINE);
      end else if (kind < 7) begin
        send_byte(ccrf_pkg::CTRL_R);
        repeat ($urandom_range(4)) send_byte(pick_byte());
        send_byte(resp_byte);
        repeat ($urandom_range(2)) send_byte(pick_byte());
        if ($urandom_range(3) != 0) send_byte(ccrf_pkg::CTRL_Z);
      end else begin
        repeat ($urandom_range(6, 1)) send_byte(pick_byte());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready per the stall knob, or a forced hold-off run.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      recv_hold = recv_hold - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h (byte %h)", $time, name, want, got,
               want_res.out_byte);
      errors++;
    end
  endtask

  // Scoreboard: every result beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      got_res.flush_queues     = res_ch.flush_queues;
      got_res.push_valid       = res_ch.push_valid;
      got_res.forward_valid    = res_ch.forward_valid;
      got_res.out_byte         = res_ch.out_byte;
      got_res.command_complete = res_ch.command_complete;
      got_res.rearbitrate      = res_ch.rearbitrate;
      got_res.cpu_response     = res_ch.cpu_response;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none got %h", $time, got_res);
        errors++;
      end else begin
        want_res = pending_results.pop_front();
        check_field("flush_queues", 8'(want_res.flush_queues),
                    8'(got_res.flush_queues));
        check_field("push_valid", 8'(want_res.push_valid), 8'(got_res.push_valid));
        check_field("forward_valid", 8'(want_res.forward_valid),
                    8'(got_res.forward_valid));
        check_field("out_byte", want_res.out_byte, got_res.out_byte);
        check_field("command_complete", 8'(want_res.command_complete),
                    8'(got_res.command_complete));
        check_field("rearbitrate", 8'(want_res.rearbitrate), 8'(got_res.rearbitrate));
        check_field("cpu_response", 8'(want_res.cpu_response),
                    8'(got_res.cpu_response));
      end
    end
  end

  // Watchdog: a hung handshake shows up as a long run with no beat at all.
  always @(posedge clk) begin
    if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results outstanding", $time,
               quiet_cycles, pending_results.size());
      $display("console_command_rx_framer_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Walk each mode and every priority branch by hand, both register settings.
  task automatic test_directed();
    logic [7:0] seq_plain[$];
    logic [7:0] seq_mfg[$];
    // Plain mode, response 0x00: command, stray newline, dropped Ctrl-X,
    // boot with response, Ctrl-R inside boot, Ctrl-R from busy, Ctrl-Z exits.
    seq_plain = '{8'h00, 8'hFF, ccrf_pkg::NEWLINE, ccrf_pkg::NEWLINE, ccrf_pkg::CTRL_X,
                  ccrf_pkg::CTRL_R, 8'h00, 8'h41, ccrf_pkg::CTRL_R, ccrf_pkg::CTRL_X,
                  ccrf_pkg::CTRL_Z, 8'h41, ccrf_pkg::CTRL_R, ccrf_pkg::CTRL_Z};
    // Manufacturing mode, response 0xFF: passthrough while ready, Ctrl-X opens
    // a command unqueued, then boot with response and a queued Ctrl-X.
    seq_mfg = '{8'h41, ccrf_pkg::CTRL_X, 8'h42, ccrf_pkg::NEWLINE, ccrf_pkg::CTRL_R,
                8'hFF, ccrf_pkg::CTRL_X, 8'h42, ccrf_pkg::CTRL_R, 8'hFF,
                ccrf_pkg::CTRL_X, ccrf_pkg::CTRL_Z};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_config(1'b0, 8'h00);
    foreach (seq_plain[i]) send_byte(seq_plain[i]);
    wait_drained();
    set_config(1'b1, 8'hFF);
    foreach (seq_mfg[i]) send_byte(seq_mfg[i]);
    wait_drained();
    // Response byte equal to Ctrl-Z: Ctrl-Z priority hides the response.
    set_config(1'b0, ccrf_pkg::CTRL_Z);
    send_byte(ccrf_pkg::CTRL_R);
    send_byte(ccrf_pkg::CTRL_Z);
    wait_drained();
  endtask

  // Receiver holds off long while the sender keeps offering, so the output
  // buffer fills and rx stalls; then the sender waits for a full drain.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_config(1'b0, 8'h55);
    recv_hold = 150;
    send_traffic(40);
    wait_drained();
    send_traffic(10);
    wait_drained();
  endtask

  // Random traffic across the idle phases, a few register settings each.
  task automatic test_random_traffic();
    logic [7:0] rsp;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(5))
          0:       rsp = 8'h00;
          1:       rsp = 8'hFF;
          2:       rsp = ccrf_pkg::CTRL_Z;
          3:       rsp = ccrf_pkg::CTRL_R;
          4:       rsp = ccrf_pkg::NEWLINE;
          default: rsp = 8'($urandom_range(255));
        endcase
        // k=0 plain, k=1 manufacturing, k=2 either.
        set_config((k == 2) ? 1'($urandom_range(1)) : (k == 1), rsp);
        send_traffic(150);
        wait_drained();
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    res_ch.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = ccrf_pkg::CFG_MANUFACTURING_MODE;
    cfg_wdata     = 8'h00;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    // Spare cycles after the drain catch any stray result beats.
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("console_command_rx_framer_unit: match");
    end else begin
      $display("console_command_rx_framer_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: console_command_rx_framer_unit.f
rtl/core/ccrf_pkg.sv
rtl/core/ccrf_rx_if.sv
rtl/core/ccrf_res_if.sv
rtl/core/ccrf_decode.sv
rtl/core/ccrf_out_buf.sv
rtl/core/console_command_rx_framer_unit.sv
tb/sv/tb_console_command_rx_framer_unit.sv
